@@ src/riscv_debug_csr_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Debug CSR unit assertion macros
// Clocked assertion helpers used by the debug CSR file RTL.
// ----------------------------------------------------------------------------
`ifndef RISCV_DEBUG_CSR_UNIT_MACROS_SVH
`define RISCV_DEBUG_CSR_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked every clock, held off during reset
`define DBGCSR_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("debug csr assertion failed");

// Consequent checked in the cycle after the antecedent
`define DBGCSR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("debug csr assertion failed");

`else

`define DBGCSR_ASSERT(label, prop)
`define DBGCSR_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ src/dbgcsr_pkg.sv @@
// ----------------------------------------------------------------------------
// Debug CSR unit package
// Request and response types, CSR addresses and register constants.
// ----------------------------------------------------------------------------
package dbgcsr_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int ADDR_WIDTH = 12;

    localparam logic [ADDR_WIDTH-1:0] ADR_MSTATUS   = 12'h300;
    localparam logic [ADDR_WIDTH-1:0] ADR_MISA      = 12'h301;
    localparam logic [ADDR_WIDTH-1:0] ADR_DCSR      = 12'h7B0;
    localparam logic [ADDR_WIDTH-1:0] ADR_DPC       = 12'h7B1;
    localparam logic [ADDR_WIDTH-1:0] ADR_DSCRATCH0 = 12'h7B2;
    localparam logic [ADDR_WIDTH-1:0] ADR_DSCRATCH1 = 12'h7B3;

    localparam logic [DATA_WIDTH-1:0] MISA_VALUE    = 32'h4000_0100;
    localparam logic [DATA_WIDTH-1:0] DCSR_WMASK    = 32'h0000_BE17;
    localparam logic [DATA_WIDTH-1:0] MSTATUS_RESET = 32'h0002_0000;
    localparam logic [DATA_WIDTH-1:0] DCSR_RESET    = 32'h4000_B003;

    localparam int DCSR_STEP_BIT  = 2;
    localparam int DCSR_CAUSE_LSB = 6;
    localparam int DCSR_CAUSE_MSB = 8;

    localparam logic [2:0] CAUSE_EBREAK  = 3'd1;
    localparam logic [2:0] CAUSE_HALTREQ = 3'd3;
    localparam logic [2:0] CAUSE_STEP    = 3'd4;

    typedef struct packed {
        logic                  read_enable;
        logic                  write_enable;
        logic [ADDR_WIDTH-1:0] csr_address;
        logic [DATA_WIDTH-1:0] write_data;
        logic [DATA_WIDTH-1:0] program_counter;
        logic                  enter_by_ebreak;
        logic                  enter_by_haltreq;
        logic                  enter_by_step;
        logic                  leave_debug;
    } req_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] read_data;
        logic [DATA_WIDTH-1:0] saved_pc;
        logic                  entering_debug;
        logic                  step_request;
    } resp_t;

endpackage

@@ src/dbgcsr_csr_file.sv @@
// ----------------------------------------------------------------------------
// Debug CSR file
// Holds mstatus, dcsr, dpc, dscratch0/1 and the debug level flag; forms the
// response for one request and updates the registers when it is taken.
// ----------------------------------------------------------------------------
`include "riscv_debug_csr_unit_macros.svh"

module dbgcsr_csr_file (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               update,
    input  dbgcsr_pkg::req_t   req,
    output dbgcsr_pkg::resp_t  resp
);

    logic [dbgcsr_pkg::DATA_WIDTH-1:0] mach_status_reg, mach_status_next;
    logic [dbgcsr_pkg::DATA_WIDTH-1:0] dbg_ctrl_reg, dbg_ctrl_next;
    logic [dbgcsr_pkg::DATA_WIDTH-1:0] dpc_reg, dpc_next;
    logic [dbgcsr_pkg::DATA_WIDTH-1:0] scratch0_reg, scratch0_next;
    logic [dbgcsr_pkg::DATA_WIDTH-1:0] scratch1_reg, scratch1_next;
    logic                              dbg_mode_reg, dbg_mode_next;
    logic [dbgcsr_pkg::DATA_WIDTH-1:0] csr_rdata;
    logic                              entering;

    assign entering = req.enter_by_ebreak | req.enter_by_haltreq | req.enter_by_step;

    always_comb
    begin
        case (req.csr_address)
            dbgcsr_pkg::ADR_MSTATUS:   csr_rdata = mach_status_reg;
            dbgcsr_pkg::ADR_MISA:      csr_rdata = dbgcsr_pkg::MISA_VALUE;
            dbgcsr_pkg::ADR_DCSR:      csr_rdata = dbg_ctrl_reg;
            dbgcsr_pkg::ADR_DPC:       csr_rdata = dpc_reg;
            dbgcsr_pkg::ADR_DSCRATCH0: csr_rdata = scratch0_reg;
            dbgcsr_pkg::ADR_DSCRATCH1: csr_rdata = scratch1_reg;
            default:                   csr_rdata = '0;
        endcase
    end

    always_comb
    begin
        resp.read_data      = req.read_enable ? csr_rdata : '0;
        resp.saved_pc       = dpc_reg;
        resp.entering_debug = entering;
        resp.step_request   = dbg_ctrl_reg[dbgcsr_pkg::DCSR_STEP_BIT] & ~dbg_mode_reg;
    end

    always_comb
    begin
        mach_status_next = mach_status_reg;
        dbg_ctrl_next    = dbg_ctrl_reg;
        dpc_next         = dpc_reg;
        scratch0_next    = scratch0_reg;
        scratch1_next    = scratch1_reg;
        dbg_mode_next    = dbg_mode_reg;

        if (req.write_enable)
        begin
            case (req.csr_address)
                dbgcsr_pkg::ADR_MSTATUS:   mach_status_next = req.write_data;
                dbgcsr_pkg::ADR_DCSR:      dbg_ctrl_next =
                                               (dbg_ctrl_reg & ~dbgcsr_pkg::DCSR_WMASK)
                                             | (req.write_data & dbgcsr_pkg::DCSR_WMASK);
                dbgcsr_pkg::ADR_DPC:       dpc_next = req.write_data;
                dbgcsr_pkg::ADR_DSCRATCH0: scratch0_next = req.write_data;
                dbgcsr_pkg::ADR_DSCRATCH1: scratch1_next = req.write_data;
                default:                   ;
            endcase
        end

        // cause field overrides a same-cycle dcsr write
        if (req.enter_by_ebreak)
            dbg_ctrl_next[dbgcsr_pkg::DCSR_CAUSE_MSB:dbgcsr_pkg::DCSR_CAUSE_LSB] =
                dbgcsr_pkg::CAUSE_EBREAK;
        else if (req.enter_by_haltreq)
            dbg_ctrl_next[dbgcsr_pkg::DCSR_CAUSE_MSB:dbgcsr_pkg::DCSR_CAUSE_LSB] =
                dbgcsr_pkg::CAUSE_HALTREQ;
        else if (req.enter_by_step)
            dbg_ctrl_next[dbgcsr_pkg::DCSR_CAUSE_MSB:dbgcsr_pkg::DCSR_CAUSE_LSB] =
                dbgcsr_pkg::CAUSE_STEP;

        if (entering && !dbg_mode_reg)
            dpc_next = req.program_counter;

        if (entering)
            dbg_mode_next = 1'b1;
        if (req.leave_debug)
            dbg_mode_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mach_status_reg <= dbgcsr_pkg::MSTATUS_RESET;
            dbg_ctrl_reg    <= dbgcsr_pkg::DCSR_RESET;
            dpc_reg         <= '0;
            scratch0_reg    <= '0;
            scratch1_reg    <= '0;
            dbg_mode_reg    <= 1'b0;
        end
        else if (update)
        begin
            mach_status_reg <= mach_status_next;
            dbg_ctrl_reg    <= dbg_ctrl_next;
            dpc_reg         <= dpc_next;
            scratch0_reg    <= scratch0_next;
            scratch1_reg    <= scratch1_next;
            dbg_mode_reg    <= dbg_mode_next;
        end
    end

    `DBGCSR_ASSERT_NEXT(a_dpc_capture, update && entering && !dbg_mode_reg,
                        dpc_reg == $past(req.program_counter))
    `DBGCSR_ASSERT_NEXT(a_leave_wins, update && req.leave_debug, !dbg_mode_reg)
    `DBGCSR_ASSERT_NEXT(a_entry_sets_level, update && entering && !req.leave_debug,
                        dbg_mode_reg)
    `DBGCSR_ASSERT_NEXT(a_hold_when_idle, !update,
                        $stable(dbg_ctrl_reg) && $stable(dpc_reg) && $stable(dbg_mode_reg))

endmodule

@@ src/riscv_debug_csr_unit.sv @@
// ----------------------------------------------------------------------------
// RISC-V debug CSR unit
// Registered request stage, CSR file update and registered response stage.
// ----------------------------------------------------------------------------
// The unit takes one request per clock cycle while the response side does not
// stall and returns one response per request: the request is captured in an
// input register, the CSR file evaluates it and updates its registers in a
// single pass, and the response is held in an output register until taken.
// A held response does not block intake; the input register keeps one
// further request while the output waits.
// ----------------------------------------------------------------------------
module riscv_debug_csr_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  dbgcsr_pkg::req_t   req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output dbgcsr_pkg::resp_t  rsp
);

    logic              in_valid_reg, in_valid_next;
    dbgcsr_pkg::req_t  in_item_reg;
    logic              out_valid_reg, out_valid_next;
    dbgcsr_pkg::resp_t out_item_reg;
    dbgcsr_pkg::resp_t result;
    logic              advance;

    // move the held request into the response register
    assign advance   = in_valid_reg && (!out_valid_reg || rsp_ready);
    assign req_ready = !in_valid_reg || advance;

    always_comb
    begin
        if (req_valid && req_ready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (advance)
            out_valid_next = 1'b1;
        else if (rsp_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    dbgcsr_csr_file u_csr_file (
        .clk    (clk),
        .rst_n  (rst_n),
        .update (advance),
        .req    (in_item_reg),
        .resp   (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
            in_item_reg <= req;
        if (advance)
            out_item_reg <= result;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_item_reg;

endmodule
